>>> hw/rtl/word_break_way_counter_top_assert.svh
// Assertion macros for the word break way counter.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef WORD_BREAK_WAY_COUNTER_TOP_ASSERT_SVH
`define WORD_BREAK_WAY_COUNTER_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define WBWC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define WBWC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define WBWC_ASSERT(lbl, prop, msg)
`define WBWC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> hw/rtl/wbwc_pkg.sv
// Shared types and defaults of the word break way counter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wbwc_pkg;
  localparam int MaxWordsDef     = 16;
  localparam int MaxWordLenDef   = 16;
  localparam int MaxTargetLenDef = 64;

  typedef enum logic [1:0] {
    CMD_WORD   = 2'd0,
    CMD_TARGET = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_value;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] way_count;
    logic        status;
  } out_beat_t;
endpackage
`default_nettype wire

>>> hw/rtl/word_break_way_counter_top.sv
// Word break way counter, top level.
// Depends on wbwc_pkg and word_break_way_counter_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
// Loads dictionary words and a target string one byte per beat, then counts
// how many ways the target splits into bank words (reuse allowed, mod 2^32).
// Load beats are taken only while idle. The beat that closes the target starts a
// pass over positions from the end: per position, each bank word reads its
// length (ST_LEN_RD, ST_LEN_CHK), compares byte by byte (ST_CMP_RD, ST_CMP_CHK)
// and on a full match adds the way count (ST_WAY_RD, ST_WAY_ADD); the end of the
// word scan and the write back (ST_WR) close each position, and ST_DONE loads the
// result register (held there while the output is stalled and still full). Input
// is stalled during the pass. Tables sit in synchronous memories with registered reads.
module word_break_way_counter_top #(
  parameter int MAX_WORDS      = wbwc_pkg::MaxWordsDef,
  parameter int MAX_WORD_LEN   = wbwc_pkg::MaxWordLenDef,
  parameter int MAX_TARGET_LEN = wbwc_pkg::MaxTargetLenDef
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wbwc_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output wbwc_pkg::out_beat_t  out_data_o
);
  import wbwc_pkg::*;
  `include "word_break_way_counter_top_assert.svh"

  localparam int WI = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int WC = $clog2(MAX_WORDS + 1);
  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int WD = MAX_WORDS * MAX_WORD_LEN;
  localparam int WA = (WD > 1) ? $clog2(WD) : 1;
  localparam int TI = (MAX_TARGET_LEN > 1) ? $clog2(MAX_TARGET_LEN) : 1;
  localparam int TL = $clog2(MAX_TARGET_LEN + 1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_LEN_RD  = 9'b000000010,
    ST_LEN_CHK = 9'b000000100,
    ST_CMP_RD  = 9'b000001000,
    ST_CMP_CHK = 9'b000010000,
    ST_WAY_RD  = 9'b000100000,
    ST_WAY_ADD = 9'b001000000,
    ST_WR      = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_e;

  // Memories
  logic [7:0]    word_mem [WD];
  logic [LW-1:0] len_mem  [MAX_WORDS];
  logic [7:0]    tgt_mem  [MAX_TARGET_LEN];
  logic [31:0]   ways_mem [MAX_TARGET_LEN];

  logic [7:0]    word_rd_q, tgt_rd_q;
  logic [LW-1:0] len_rd_q;
  logic [31:0]   ways_rd_q;

  state_e        state_q, state_d;
  logic [WC-1:0] total_q, total_d, w_q, w_d;
  logic [LW-1:0] bl_q, bl_d, k_q, k_d, len_q, len_d, bl_new;
  logic [TL-1:0] tlen_q, tlen_d, pos_q, pos_d;
  logic [31:0]   sum_q, sum_d;
  logic          ovf_q, ovf_d;
  logic          out_valid_q, out_valid_d;
  out_beat_t     out_q, out_d;

  logic          accept;
  cmd_e          cmd;
  logic          word_we, len_we, tgt_we, ways_we;
  logic [WA-1:0] word_waddr, word_raddr;
  logic [TI-1:0] tgt_raddr, ways_raddr;
  logic          at_end;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign cmd         = cmd_e'(in_data_i.command);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign bl_new     = (int'(bl_q) < MAX_WORD_LEN) ? LW'(int'(bl_q) + 1) : bl_q;
  assign word_waddr = WA'(int'(total_q) * MAX_WORD_LEN + int'(bl_q));
  assign word_raddr = WA'(int'(w_q) * MAX_WORD_LEN + int'(k_q));
  assign tgt_raddr  = TI'(int'(pos_q) + int'(k_q));
  assign ways_raddr = TI'(int'(pos_q) + int'(len_q));
  // A match that reaches the end of the target contributes exactly one way.
  assign at_end     = (int'(pos_q) + int'(len_q)) == int'(tlen_q);

  assign word_we = accept && cmd == CMD_WORD && int'(total_q) < MAX_WORDS
                   && int'(bl_q) < MAX_WORD_LEN;
  assign len_we  = accept && cmd == CMD_WORD && int'(total_q) < MAX_WORDS
                   && in_data_i.last;
  assign tgt_we  = accept && cmd == CMD_TARGET && int'(tlen_q) < MAX_TARGET_LEN;
  assign ways_we = (state_q == ST_WR);

  always_ff @(posedge clk_i) begin
    if (word_we) word_mem[word_waddr] <= in_data_i.char_value;
    if (len_we) len_mem[total_q[WI-1:0]] <= bl_new;
    if (tgt_we) tgt_mem[tlen_q[TI-1:0]] <= in_data_i.char_value;
    if (ways_we) ways_mem[pos_q[TI-1:0]] <= sum_q;
    word_rd_q <= word_mem[word_raddr];
    len_rd_q  <= len_mem[w_q[WI-1:0]];
    tgt_rd_q  <= tgt_mem[tgt_raddr];
    ways_rd_q <= ways_mem[ways_raddr];
  end

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    bl_d        = bl_q;
    tlen_d      = tlen_q;
    ovf_d       = ovf_q;
    w_d         = w_q;
    k_d         = k_q;
    len_d       = len_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            CMD_WORD: begin
              if (int'(total_q) >= MAX_WORDS) begin
                ovf_d = 1'b1;
              end else begin
                if (int'(bl_q) >= MAX_WORD_LEN) ovf_d = 1'b1;
                bl_d = bl_new;
                if (in_data_i.last) begin
                  total_d = WC'(int'(total_q) + 1);
                  bl_d    = '0;
                end
              end
            end
            CMD_TARGET: begin
              if (int'(tlen_q) < MAX_TARGET_LEN) tlen_d = TL'(int'(tlen_q) + 1);
              else ovf_d = 1'b1;
              if (in_data_i.last) begin
                // Start the pass at the last position.
                pos_d   = (int'(tlen_q) < MAX_TARGET_LEN) ? tlen_q
                                                          : TL'(int'(tlen_q) - 1);
                w_d     = '0;
                sum_d   = '0;
                state_d = ST_LEN_RD;
              end
            end
            CMD_CLEAR: begin
              total_d = '0;
              bl_d    = '0;
              ovf_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_LEN_RD: begin
        state_d = (w_q == total_q) ? ST_WR : ST_LEN_CHK;
      end
      ST_LEN_CHK: begin
        len_d = len_rd_q;
        k_d   = '0;
        if (int'(len_rd_q) + int'(pos_q) > int'(tlen_q)) begin
          w_d     = WC'(int'(w_q) + 1);
          state_d = ST_LEN_RD;
        end else begin
          state_d = ST_CMP_RD;
        end
      end
      ST_CMP_RD: state_d = ST_CMP_CHK;
      ST_CMP_CHK: begin
        priority if (word_rd_q != tgt_rd_q) begin
          w_d     = WC'(int'(w_q) + 1);
          state_d = ST_LEN_RD;
        end else if (int'(k_q) + 1 == int'(len_q)) begin
          state_d = ST_WAY_RD;
        end else begin
          k_d     = LW'(int'(k_q) + 1);
          state_d = ST_CMP_RD;
        end
      end
      ST_WAY_RD: state_d = ST_WAY_ADD;
      ST_WAY_ADD: begin
        sum_d   = sum_q + (at_end ? 32'd1 : ways_rd_q);
        w_d     = WC'(int'(w_q) + 1);
        state_d = ST_LEN_RD;
      end
      ST_WR: begin
        if (pos_q == '0) begin
          state_d = ST_DONE;
        end else begin
          pos_d   = TL'(int'(pos_q) - 1);
          w_d     = '0;
          sum_d   = '0;
          state_d = ST_LEN_RD;
        end
      end
      ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_q || !out_stall_i) begin
          out_d.way_count = sum_q;
          out_d.status    = ovf_q;
          out_valid_d     = 1'b1;
          ovf_d           = 1'b0;
          tlen_d          = '0;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      bl_q        <= '0;
      tlen_q      <= '0;
      ovf_q       <= 1'b0;
      w_q         <= '0;
      k_q         <= '0;
      len_q       <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      bl_q        <= bl_d;
      tlen_q      <= tlen_d;
      ovf_q       <= ovf_d;
      w_q         <= w_d;
      k_q         <= k_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  `WBWC_ASSERT(a_bank_bound, int'(total_q) <= MAX_WORDS, "word count past capacity")
  `WBWC_ASSERT(a_tgt_bound, int'(tlen_q) <= MAX_TARGET_LEN, "target past capacity")
  `WBWC_ASSERT(a_pos_in_tgt, (state_q != ST_IDLE && state_q != ST_DONE) |-> pos_q < tlen_q, "position outside target")
  `WBWC_ASSERT(a_rise_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE), "result without a pass")
  `WBWC_ASSERT(a_word_scan, state_q == ST_LEN_CHK |-> w_q < total_q, "word index past bank")
endmodule
`default_nettype wire
